@@ rtl/rmss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmss_pkg
// shared types, codes and defaults of the rating matrix similarity search
// ----------------------------------------------------------------------------
package rmss_pkg;

  // default matrix shape
  localparam int MEMBERS_DEF = 64;
  localparam int BOOKS_DEF   = 64;

  // width that holds any legal member or book count
  localparam int IDX_EXT_W = 11;

  // field widths of the item channels
  localparam int FUNC_W    = 2;
  localparam int MEMBER_W  = 6;
  localparam int BOOK_W    = 6;
  localparam int RATING_W  = 8;
  localparam int PRODUCT_W = 2 * RATING_W;

  // request codes on in_func
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // command queue depth, power of two
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_READ,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [MEMBER_W-1:0] member;
    logic [BOOK_W-1:0]   book;
    logic [RATING_W-1:0] value;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_QRUN,
    ST_QDRAIN
  } back_state_t;

endpackage : rmss_pkg
`default_nettype wire

@@ rtl/rmss_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmss_front
// accepts request items, range checks and decodes them into queue commands
// ----------------------------------------------------------------------------
module rmss_front
  import rmss_pkg::*;
#(
  parameter int MEMBERS = MEMBERS_DEF,
  parameter int BOOKS   = BOOKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [MEMBER_W-1:0] in_member_index,
  input  wire logic [BOOK_W-1:0]   in_book_index,
  input  wire logic [RATING_W-1:0] in_rating_value,
  input  wire logic                q_full,
  input  wire logic                clearing,
  output logic                     push,
  output cmd_t                     push_cmd
);

  localparam logic [IDX_EXT_W-1:0] MEMBERS_X = IDX_EXT_W'(MEMBERS);
  localparam logic [IDX_EXT_W-1:0] BOOKS_X   = IDX_EXT_W'(BOOKS);

  logic member_ok;
  logic book_ok;
  op_t  op;

  assign member_ok = IDX_EXT_W'(in_member_index) < MEMBERS_X;
  assign book_ok   = IDX_EXT_W'(in_book_index) < BOOKS_X;

  // out of range accesses and the unused code turn into a plain acknowledge
  always_comb begin
    unique case (in_func)
      FUNC_WRITE: op = (member_ok && book_ok) ? OP_WRITE : OP_NOP;
      FUNC_READ:  op = (member_ok && book_ok) ? OP_READ : OP_NOP;
      FUNC_QUERY: op = member_ok ? OP_QUERY : OP_NOP;
      default:    op = OP_NOP;
    endcase
  end

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  assign push_cmd.op     = op;
  assign push_cmd.member = in_member_index;
  assign push_cmd.book   = in_book_index;
  assign push_cmd.value  = in_rating_value;

  // stall must cover the whole clearing pass
  a_stall_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !push)
    else $error("item accepted during clearing pass");

endmodule : rmss_front
`default_nettype wire

@@ rtl/rmss_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmss_queue
// short command queue between the front end and the back end
// ----------------------------------------------------------------------------
module rmss_queue
  import rmss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output head_t     head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full       = (count_r == CNT_FULL);
  assign head.valid = (count_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

endmodule : rmss_queue
`default_nettype wire

@@ rtl/rmss_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmss_back
// rating memory, clearing pass, read/write service and the dot product search
// ----------------------------------------------------------------------------
module rmss_back
  import rmss_pkg::*;
#(
  parameter int MEMBERS = MEMBERS_DEF,
  parameter int BOOKS   = BOOKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire head_t               head,
  output logic                     pop,
  output logic                     clearing,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [RATING_W-1:0]      out_rating_out,
  output logic [MEMBER_W-1:0]      out_similar_member
);

  localparam int DEPTH = MEMBERS * BOOKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ABW   = $clog2(DEPTH + 1);
  localparam int RCW   = $clog2(MEMBERS + 1);
  localparam int CW    = (BOOKS > 1) ? $clog2(BOOKS) : 1;
  localparam int SW    = PRODUCT_W + $clog2(BOOKS) + 1;

  localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);
  localparam logic [ABW-1:0] BOOKS_A  = ABW'(BOOKS);
  localparam logic [RCW-1:0] ROW_END  = RCW'(MEMBERS);
  localparam logic [CW-1:0]  COL_LAST = CW'(BOOKS - 1);

  back_state_t state_r, state_nxt;

  logic signed [RATING_W-1:0] mem [DEPTH];
  logic signed [RATING_W-1:0] rd_a_r, rd_b_r;

  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [RCW-1:0] who_r, who_nxt;
  logic [ABW-1:0] who_base_r, who_base_nxt;
  logic [RCW-1:0] row_r, row_nxt;
  logic [ABW-1:0] row_base_r, row_base_nxt;
  logic [CW-1:0]  col_r, col_nxt;

  // datapath pipeline: read, multiply, accumulate, compare
  logic                        s1_valid_r, s1_last_r;
  logic [RCW-1:0]              s1_row_r;
  logic                        p2_valid_r, p2_last_r;
  logic [RCW-1:0]              p2_row_r;
  logic signed [PRODUCT_W-1:0] p2_r;
  logic signed [SW-1:0]        acc_r, acc_sum;
  logic                        s3_valid_r;
  logic [RCW-1:0]              s3_row_r;
  logic signed [SW-1:0]        s3_score_r;
  logic signed [SW-1:0]        best_r;
  logic                        have_best_r;
  logic [RCW-1:0]              pick_r;

  logic                   out_valid_r;
  logic [RATING_W-1:0]    out_rating_r;
  logic [MEMBER_W-1:0]    out_similar_r;

  logic                   out_free, out_load, drained;
  logic [RATING_W-1:0]    ld_rating;
  logic [MEMBER_W-1:0]    ld_similar;
  logic                   mem_we, rd_en, issue, issue_last, q_start;
  logic [AW-1:0]          mem_waddr, addr_a, addr_b;
  logic [RATING_W-1:0]    mem_wdata;
  logic [ABW-1:0]         rw_base, rw_sum, qa_sum, qb_sum;

  assign out_free = !out_valid_r || !out_stall;
  assign drained  = !s1_valid_r && !p2_valid_r && !s3_valid_r;

  assign rw_base = ABW'(head.cmd.member) * BOOKS_A;
  assign rw_sum  = rw_base + ABW'(head.cmd.book);
  assign qa_sum  = who_base_r + ABW'(col_r);
  assign qb_sum  = row_base_r + ABW'(col_r);
  assign issue_last = (col_r == COL_LAST);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    who_nxt      = who_r;
    who_base_nxt = who_base_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    col_nxt      = col_r;
    pop          = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_r;
    mem_wdata    = '0;
    rd_en        = 1'b0;
    addr_a       = rw_sum[AW-1:0];
    addr_b       = qb_sum[AW-1:0];
    issue        = 1'b0;
    q_start      = 1'b0;
    out_load     = 1'b0;
    ld_rating    = '0;
    ld_similar   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.op)
            OP_NOP, OP_WRITE: begin
              if (out_free) begin
                pop       = 1'b1;
                out_load  = 1'b1;
                mem_we    = (head.cmd.op == OP_WRITE);
                mem_waddr = rw_sum[AW-1:0];
                mem_wdata = head.cmd.value;
              end
            end
            OP_READ: begin
              pop       = 1'b1;
              rd_en     = 1'b1;
              state_nxt = ST_READ;
            end
            OP_QUERY: begin
              pop          = 1'b1;
              q_start      = 1'b1;
              who_nxt      = RCW'(head.cmd.member);
              who_base_nxt = rw_base;
              row_nxt      = '0;
              row_base_nxt = '0;
              col_nxt      = '0;
              state_nxt    = ST_QRUN;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_rating = rd_a_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_QRUN: begin
        addr_a = qa_sum[AW-1:0];
        if (row_r == ROW_END) begin
          state_nxt = ST_QDRAIN;
        end else if (row_r == who_r) begin
          // own row is skipped
          row_nxt      = row_r + 1'b1;
          row_base_nxt = row_base_r + BOOKS_A;
        end else begin
          rd_en = 1'b1;
          issue = 1'b1;
          if (issue_last) begin
            col_nxt      = '0;
            row_nxt      = row_r + 1'b1;
            row_base_nxt = row_base_r + BOOKS_A;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      ST_QDRAIN: begin
        if (drained && out_free) begin
          out_load   = 1'b1;
          ld_similar = MEMBER_W'(pick_r);
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    who_r      <= who_nxt;
    who_base_r <= who_base_nxt;
    row_r      <= row_nxt;
    row_base_r <= row_base_nxt;
    col_r      <= col_nxt;
  end

  // rating memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  assign acc_sum = acc_r + SW'(p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      acc_r       <= '0;
      have_best_r <= 1'b0;
      pick_r      <= '0;
    end else begin
      s1_valid_r <= issue;
      p2_valid_r <= s1_valid_r;
      s3_valid_r <= p2_valid_r && p2_last_r;
      if (p2_valid_r) begin
        acc_r <= p2_last_r ? '0 : acc_sum;
      end
      if (q_start) begin
        have_best_r <= 1'b0;
        pick_r      <= '0;
      end else if (s3_valid_r && (!have_best_r || s3_score_r > best_r)) begin
        have_best_r <= 1'b1;
        pick_r      <= s3_row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r  <= issue_last;
    s1_row_r   <= row_r;
    p2_last_r  <= s1_last_r;
    p2_row_r   <= s1_row_r;
    p2_r       <= rd_a_r * rd_b_r;
    s3_row_r   <= p2_row_r;
    s3_score_r <= acc_sum;
    if (s3_valid_r && (!have_best_r || s3_score_r > best_r)) begin
      best_r <= s3_score_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rating_r  <= ld_rating;
      out_similar_r <= ld_similar;
    end
  end

  assign clearing           = (state_r == ST_CLEAR);
  assign out_valid          = out_valid_r;
  assign out_rating_out     = out_rating_r;
  assign out_similar_member = out_similar_r;

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwritten before taken");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !pop)
    else $error("command taken during clearing pass");

  a_score_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (state_r == ST_QRUN || state_r == ST_QDRAIN))
    else $error("row score outside a query");

endmodule : rmss_back
`default_nettype wire

@@ rtl/rating_matrix_similarity_search_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rating_matrix_similarity_search_top
// member-by-book rating matrix with dot product nearest neighbor search
// ----------------------------------------------------------------------------
// The block holds a MEMBERS x BOOKS matrix of signed 8-bit ratings. After
// reset a clearing pass writes zero to every entry, one per cycle, and
// in_stall stays high until it ends. Each accepted item gives exactly one
// result item: a write returns an all-zero acknowledge, a read returns the
// stored rating, a query returns the lowest numbered other member whose row
// has the greatest dot product with the queried row (0 when there is no
// other member). Out of range indices (a query checks only its member
// index) and func code 3 give an all-zero result and change nothing. A
// front end decodes items into a two-entry command queue; the back end
// services one command at a time. Writes and acknowledges are answered
// from the idle state, reads go through a read state first. A query runs
// one multiply-accumulate per cycle, apart from its skipped own row, fed by
// the two read ports of the rating memory. The result sits in an output
// register, so the next item can be accepted while it waits.
// ----------------------------------------------------------------------------
module rating_matrix_similarity_search_top
  import rmss_pkg::*;
#(
  parameter int MEMBERS = MEMBERS_DEF,
  parameter int BOOKS   = BOOKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request items
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [MEMBER_W-1:0] in_member_index,
  input  wire logic [BOOK_W-1:0]   in_book_index,
  input  wire logic [RATING_W-1:0] in_rating_value,
  // result items
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [RATING_W-1:0]      out_rating_out,
  output logic [MEMBER_W-1:0]      out_similar_member
);

  // front to queue
  logic  push;
  cmd_t  push_cmd;
  logic  q_full;
  // queue to back
  head_t head;
  logic  pop;
  // back end busy with the clearing pass
  logic  clearing;

  // decode and range check, stall while queue full or memory clearing
  rmss_front #(
    .MEMBERS (MEMBERS),
    .BOOKS   (BOOKS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_member_index (in_member_index),
    .in_book_index   (in_book_index),
    .in_rating_value (in_rating_value),
    .q_full          (q_full),
    .clearing        (clearing),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // decoupling queue
  rmss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // memory, search datapath and output register
  rmss_back #(
    .MEMBERS (MEMBERS),
    .BOOKS   (BOOKS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rating_out     (out_rating_out),
    .out_similar_member (out_similar_member)
  );

endmodule : rating_matrix_similarity_search_top
`default_nettype wire
